// ===== hdl/tmn_pkg.sv =====
package tmn_pkg;

    // Sample and window geometry.
    localparam int SAMPLE_W       = 12;
    localparam int CHANNELS       = 4;
    localparam int CH_W           = $clog2(CHANNELS);
    localparam int WINDOW_SAMPLES = 5;
    localparam int CNT_W          = $clog2(WINDOW_SAMPLES);
    localparam int SUM_W          = SAMPLE_W + CNT_W;
    localparam int TRIM_DIV       = WINDOW_SAMPLES - 2;

    // Reciprocal of the trimmed sample count, used for the mean.
    localparam int RECIP_SHIFT = SUM_W;
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'((64'd1 << RECIP_SHIFT) / TRIM_DIV);

    // Output scaling: 0 to 500 with four fraction bits.
    localparam int LEVEL_W       = 13;
    localparam int FULL_SCALE    = 8000;
    localparam int NUM_W         = SAMPLE_W + LEVEL_W;
    localparam int STEP_W        = $clog2(LEVEL_W);
    localparam int CEILING_RESET = 3800;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = CHANNELS * SAMPLE_W;
    localparam int OUT_DATA_W = ((CHANNELS * LEVEL_W + 7) / 8) * 8;

    // Configuration register map.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_FLOOR,
        REG_LEFT_CEILING,
        REG_RIGHT_FLOOR,
        REG_RIGHT_CEILING,
        REG_LDIAG_FLOOR,
        REG_LDIAG_CEILING,
        REG_RDIAG_FLOOR,
        REG_RDIAG_CEILING
    } t_cfg_reg;

    // One finished window: per channel sum, largest and smallest sample.
    typedef struct packed {
        logic [CHANNELS-1:0][SUM_W-1:0]    sum;
        logic [CHANNELS-1:0][SAMPLE_W-1:0] peak;
        logic [CHANNELS-1:0][SAMPLE_W-1:0] trough;
    } t_window;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_TRIM,
        BK_RECIP,
        BK_FIX,
        BK_SCALE,
        BK_DIV,
        BK_EMIT
    } t_back_state;

endpackage

// ===== hdl/tmn_front.sv =====
module tmn_front
    import tmn_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // left_sample, right_sample, left_diag_sample, right_diag_sample
    input  logic [IN_DATA_W-1:0] i_s_tdata,
    input  t_queue_status        i_queue,
    output logic                 o_push,
    output t_window              o_entry
);

    logic [CNT_W-1:0]                  r_count, n_count;
    logic [CHANNELS-1:0][SUM_W-1:0]    r_sum, n_sum;
    logic [CHANNELS-1:0][SAMPLE_W-1:0] r_peak, n_peak;
    logic [CHANNELS-1:0][SAMPLE_W-1:0] r_trough, n_trough;
    logic                              first_item;
    logic                              last_item;
    logic                              accept;

    // Window bookkeeping; the last item of a window needs room in the queue.
    always_comb begin
        first_item = (r_count == '0);
        last_item  = (r_count == CNT_W'(WINDOW_SAMPLES - 1));
        o_s_tready = !(last_item && i_queue.full);
        accept     = i_s_tvalid && o_s_tready;
        n_count    = last_item ? '0 : r_count + 1'b1;
    end

    // Running sum, maximum and minimum per channel.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            if (first_item) begin
                n_sum[c]    = SUM_W'(i_s_tdata[c*SAMPLE_W +: SAMPLE_W]);
                n_peak[c]   = i_s_tdata[c*SAMPLE_W +: SAMPLE_W];
                n_trough[c] = i_s_tdata[c*SAMPLE_W +: SAMPLE_W];
            end else begin
                n_sum[c]    = r_sum[c] + SUM_W'(i_s_tdata[c*SAMPLE_W +: SAMPLE_W]);
                n_peak[c]   = (i_s_tdata[c*SAMPLE_W +: SAMPLE_W] > r_peak[c]) ?
                              i_s_tdata[c*SAMPLE_W +: SAMPLE_W] : r_peak[c];
                n_trough[c] = (i_s_tdata[c*SAMPLE_W +: SAMPLE_W] < r_trough[c]) ?
                              i_s_tdata[c*SAMPLE_W +: SAMPLE_W] : r_trough[c];
            end
        end
    end

    // A completed window goes to the queue on its last transfer.
    assign o_push         = accept && last_item;
    assign o_entry.sum    = n_sum;
    assign o_entry.peak   = n_peak;
    assign o_entry.trough = n_trough;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sum    <= n_sum;
            r_peak   <= n_peak;
            r_trough <= n_trough;
        end
    end

endmodule

// ===== hdl/tmn_queue.sv =====
module tmn_queue
    import tmn_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_window       i_entry,
    input  logic          i_pop,
    output t_queue_status o_status,
    output t_window       o_head
);

    t_window           r_store [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_fill;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] ptr);
        return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    assign o_status.full  = (r_fill == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_fill == '0);
    assign o_head         = r_store[r_rd_ptr];

    // Pointer and fill tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // Window storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== hdl/tmn_back.sv =====
module tmn_back
    import tmn_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_queue_status                     i_queue,
    input  t_window                           i_head,
    output logic                              o_pop,
    input  logic [CHANNELS-1:0][SAMPLE_W-1:0] i_floor,
    input  logic [CHANNELS-1:0][SAMPLE_W-1:0] i_ceiling,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // left_level, right_level, left_diag_level, right_diag_level, zero fill
    output logic [OUT_DATA_W-1:0]             o_m_tdata
);

    t_back_state                      r_state, n_state;
    logic [CH_W-1:0]                  r_ch, n_ch;
    logic [SUM_W-1:0]                 r_rest, n_rest;
    logic [PROD_W-1:0]                r_prod, n_prod;
    logic [SAMPLE_W-1:0]              r_mean, n_mean;
    logic [SAMPLE_W-1:0]              r_rem, n_rem;
    logic [SAMPLE_W-1:0]              r_den, n_den;
    logic [LEVEL_W-1:0]               r_quo, n_quo;
    logic [STEP_W-1:0]                r_step, n_step;
    logic [CHANNELS-1:0][LEVEL_W-1:0] r_level, n_level;
    logic                             r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]            r_out_data, n_out_data;

    logic [SUM_W-1:0]    q_est;
    logic [SUM_W-1:0]    q_rem;
    logic [SUM_W-1:0]    q_mean;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [NUM_W-1:0]    num;
    logic [SAMPLE_W:0]   shifted;
    logic [SAMPLE_W:0]   trial;
    logic                fits;
    logic                fin;
    logic [LEVEL_W-1:0]  fin_level;

    // Datapath helpers shared by several states.
    always_comb begin
        q_est   = SUM_W'(r_prod >> RECIP_SHIFT);
        q_rem   = r_rest - SUM_W'(q_est * SUM_W'(TRIM_DIV));
        q_mean  = (q_rem >= SUM_W'(TRIM_DIV)) ? q_est + 1'b1 : q_est;
        lo      = i_floor[r_ch];
        hi      = i_ceiling[r_ch];
        num     = NUM_W'(r_mean - lo) * NUM_W'(FULL_SCALE);
        shifted = {r_rem, r_quo[LEVEL_W-1]};
        fits    = (shifted >= {1'b0, r_den});
        trial   = shifted - {1'b0, r_den};
    end

    // Sequencer: per channel trim, mean, scale, then a one-bit-a-cycle divide when the mean is in range.
    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_rest      = r_rest;
        n_prod      = r_prod;
        n_mean      = r_mean;
        n_rem       = r_rem;
        n_den       = r_den;
        n_quo       = r_quo;
        n_step      = r_step;
        n_level     = r_level;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        fin         = 1'b0;
        fin_level   = '0;

        // The output slot empties on a transfer.
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            BK_IDLE: begin
                if (!i_queue.empty) begin
                    n_ch    = '0;
                    n_state = BK_TRIM;
                end
            end
            BK_TRIM: begin
                n_rest  = i_head.sum[r_ch] - SUM_W'(i_head.peak[r_ch])
                          - SUM_W'(i_head.trough[r_ch]);
                n_state = BK_RECIP;
            end
            BK_RECIP: begin
                n_prod  = PROD_W'(r_rest) * PROD_W'(RECIP_MULT);
                n_state = BK_FIX;
            end
            BK_FIX: begin
                n_mean  = q_mean[SAMPLE_W-1:0];
                n_state = BK_SCALE;
            end
            BK_SCALE: begin
                if (r_mean <= lo) begin
                    fin       = 1'b1;
                    fin_level = '0;
                end else if (hi <= lo || r_mean >= hi) begin
                    fin       = 1'b1;
                    fin_level = LEVEL_W'(FULL_SCALE);
                end else begin
                    // Below the ceiling the quotient fits the level width.
                    n_rem   = num[NUM_W-1:LEVEL_W];
                    n_quo   = num[LEVEL_W-1:0];
                    n_den   = hi - lo;
                    n_step  = '0;
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                n_rem  = fits ? trial[SAMPLE_W-1:0] : shifted[SAMPLE_W-1:0];
                n_quo  = {r_quo[LEVEL_W-2:0], fits};
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(LEVEL_W - 1)) begin
                    fin       = 1'b1;
                    fin_level = {r_quo[LEVEL_W-2:0], fits};
                end
            end
            BK_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    for (int c = 0; c < CHANNELS; c++) begin
                        n_out_data[c*LEVEL_W +: LEVEL_W] = r_level[c];
                    end
                    o_pop   = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        // A channel is done: store its level and move on.
        if (fin) begin
            n_level[r_ch] = fin_level;
            if (r_ch == CH_W'(CHANNELS - 1)) begin
                n_state = BK_EMIT;
            end else begin
                n_ch    = r_ch + 1'b1;
                n_state = BK_TRIM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_ch        <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rest     <= n_rest;
        r_prod     <= n_prod;
        r_mean     <= n_mean;
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_quo      <= n_quo;
        r_level    <= n_level;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== hdl/trimmed_mean_normalizer.sv =====
// A window's result follows the transfer of its last item: a dispatch state, then per channel
// the trim, reciprocal, fix and scale states, the divide when the mean is in range, and an emit.
// Items are taken one per cycle, but the last item of a window waits while the two-window queue
// is full; the back end takes one window at a time, its pace set by the single one-bit-per-cycle
// divider that the four channels share.
// Reset (synchronous, active low) empties the window, the queue and the output; floors go to 0.
module trimmed_mean_normalizer
    import tmn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // left_sample, right_sample, left_diag_sample, right_diag_sample
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // left_level, right_level, left_diag_level, right_diag_level, zero fill
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SAMPLE_W-1:0]   i_cfg_data
);

    logic [CHANNELS-1:0][SAMPLE_W-1:0] r_floor;
    logic [CHANNELS-1:0][SAMPLE_W-1:0] r_ceiling;
    logic                              w_push;
    logic                              w_pop;
    t_window                           w_entry;
    t_window                           w_head;
    t_queue_status                     w_status;

    // Configuration registers, always ready for a transfer.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_floor[c]   <= '0;
                r_ceiling[c] <= SAMPLE_W'(CEILING_RESET);
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_LEFT_FLOOR:    r_floor[0]   <= i_cfg_data;
                REG_LEFT_CEILING:  r_ceiling[0] <= i_cfg_data;
                REG_RIGHT_FLOOR:   r_floor[1]   <= i_cfg_data;
                REG_RIGHT_CEILING: r_ceiling[1] <= i_cfg_data;
                REG_LDIAG_FLOOR:   r_floor[2]   <= i_cfg_data;
                REG_LDIAG_CEILING: r_ceiling[2] <= i_cfg_data;
                REG_RDIAG_FLOOR:   r_floor[3]   <= i_cfg_data;
                REG_RDIAG_CEILING: r_ceiling[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tmn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_queue    (w_status),
        .o_push     (w_push),
        .o_entry    (w_entry)
    );

    tmn_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_status (w_status),
        .o_head   (w_head)
    );

    tmn_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_queue    (w_status),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .i_floor    (r_floor),
        .i_ceiling  (r_ceiling),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // The front never pushes a window into a full queue.
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_status.full)
        else $error("window pushed into a full queue");

    // The back end only retires a window that is present.
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_status.empty)
        else $error("window popped from an empty queue");

    // Retiring a window always loads the output slot.
    a_pop_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_m_tvalid)
        else $error("window retired without a result");

    // Every delivered level stays within full scale.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[0*LEVEL_W +: LEVEL_W] <= LEVEL_W'(FULL_SCALE)) &&
                       (o_m_tdata[1*LEVEL_W +: LEVEL_W] <= LEVEL_W'(FULL_SCALE)) &&
                       (o_m_tdata[2*LEVEL_W +: LEVEL_W] <= LEVEL_W'(FULL_SCALE)) &&
                       (o_m_tdata[3*LEVEL_W +: LEVEL_W] <= LEVEL_W'(FULL_SCALE)))
        else $error("level above full scale");

endmodule

// ===== sim/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmn_pkg::*;

    localparam int SETTLE_CYCLES = 100;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 170;
    localparam int PRINT_CAP     = 40;
    localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;

    // Four levels of one finished window, channel 0 in the lowest slot.
    typedef logic [CHANNELS-1:0][LEVEL_W-1:0] t_level_set;

    // How the samples of one channel are drawn over a window.
    typedef enum int {
        MIX_UNIFORM,
        MIX_NEAR_FLOOR,
        MIX_NEAR_CEILING,
        MIX_RAILS,
        MIX_CLUSTER
    } t_sample_mix;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    // left_sample, right_sample, left_diag_sample, right_diag_sample
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    // left_level, right_level, left_diag_level, right_diag_level, zero fill
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [SAMPLE_W-1:0]   i_cfg_data  = '0;

    trimmed_mean_normalizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Register map per channel.
    const t_cfg_reg floor_reg_of[CHANNELS] =
        '{REG_LEFT_FLOOR, REG_RIGHT_FLOOR, REG_LDIAG_FLOOR, REG_RDIAG_FLOOR};
    const t_cfg_reg ceiling_reg_of[CHANNELS] =
        '{REG_LEFT_CEILING, REG_RIGHT_CEILING, REG_LDIAG_CEILING, REG_RDIAG_CEILING};
    const string channel_name[CHANNELS] = '{"left", "right", "left_diag", "right_diag"};

    // Shadow of the configuration and of the window accumulators.
    int unsigned floor_cfg[CHANNELS]   = '{0, 0, 0, 0};
    int unsigned ceiling_cfg[CHANNELS] = '{CEILING_RESET, CEILING_RESET, CEILING_RESET,
                                           CEILING_RESET};
    int unsigned win_fill;
    int unsigned win_sum[CHANNELS];
    int unsigned win_peak[CHANNELS];
    int unsigned win_trough[CHANNELS];

    logic [IN_DATA_W-1:0] sets_pending[$];
    t_level_set           level_sets_due[$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int sets_taken;
    int level_sets_checked;
    int reg_writes;
    int setups;

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_CAP) begin
            $display("MISMATCH at %0t ns: %s", $realtime, what);
        end
        mismatches++;
    endtask

    // Linear map of a trimmed mean onto 0..8000, clamped at both ends.
    function automatic logic [LEVEL_W-1:0] map_level(input int unsigned mean,
                                                     input int unsigned lo,
                                                     input int unsigned hi);
        int unsigned q;
        if (mean <= lo) begin
            return '0;
        end
        if (hi <= lo) begin
            return LEVEL_W'(FULL_SCALE);
        end
        q = ((mean - lo) * FULL_SCALE) / (hi - lo);
        return (q > FULL_SCALE) ? LEVEL_W'(FULL_SCALE) : LEVEL_W'(q);
    endfunction

    // Fold one accepted sample set into the window; a full window yields its levels.
    task automatic window_accumulate(input logic [IN_DATA_W-1:0] word);
        t_level_set  levels;
        int unsigned s;
        int unsigned mean;
        for (int c = 0; c < CHANNELS; c++) begin
            s = 32'(word[c*SAMPLE_W +: SAMPLE_W]);
            if (win_fill == 0) begin
                win_sum[c]    = s;
                win_peak[c]   = s;
                win_trough[c] = s;
            end else begin
                win_sum[c] += s;
                if (s > win_peak[c]) win_peak[c] = s;
                if (s < win_trough[c]) win_trough[c] = s;
            end
        end
        win_fill++;
        if (win_fill == WINDOW_SAMPLES) begin
            for (int c = 0; c < CHANNELS; c++) begin
                mean = (win_sum[c] - win_peak[c] - win_trough[c]) / TRIM_DIV;
                levels[c] = map_level(mean, floor_cfg[c], ceiling_cfg[c]);
            end
            level_sets_due.push_back(levels);
            win_fill = 0;
        end
    endtask

    // Sample driver: presents queued sets, idling at random between transfers.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                window_accumulate(i_s_tdata);
                sets_taken++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (sets_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_tdata  <= sets_pending.pop_front();
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Level monitor: compares each transfer with the oldest expected window.
    always @(posedge i_clk) begin
        t_level_set          want;
        logic [LEVEL_W-1:0]  got;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (level_sets_due.size() == 0) begin
                    flag_mismatch($sformatf("level set 0x%0h with no window pending",
                                            o_m_tdata));
                end else begin
                    want = level_sets_due.pop_front();
                    for (int c = 0; c < CHANNELS; c++) begin
                        got = o_m_tdata[c*LEVEL_W +: LEVEL_W];
                        if (got !== want[c]) begin
                            flag_mismatch($sformatf("window %0d %s_level got %0d want %0d",
                                                    level_sets_checked, channel_name[c],
                                                    got, want[c]));
                        end
                    end
                    if (o_m_tdata[OUT_DATA_W-1:CHANNELS*LEVEL_W] !== '0) begin
                        flag_mismatch($sformatf("window %0d fill bits not zero",
                                                level_sets_checked));
                    end
                    level_sets_checked++;
                end
            end
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Register write; called right after a rising edge, returns right after one.
    task automatic write_reg(input t_cfg_reg idx, input logic [SAMPLE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_LEFT_FLOOR:    floor_cfg[0]   = 32'(val);
            REG_LEFT_CEILING:  ceiling_cfg[0] = 32'(val);
            REG_RIGHT_FLOOR:   floor_cfg[1]   = 32'(val);
            REG_RIGHT_CEILING: ceiling_cfg[1] = 32'(val);
            REG_LDIAG_FLOOR:   floor_cfg[2]   = 32'(val);
            REG_LDIAG_CEILING: ceiling_cfg[2] = 32'(val);
            REG_RDIAG_FLOOR:   floor_cfg[3]   = 32'(val);
            REG_RDIAG_CEILING: ceiling_cfg[3] = 32'(val);
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic program_channel(input int c, input int unsigned lo, input int unsigned hi);
        write_reg(floor_reg_of[c], SAMPLE_W'(lo));
        write_reg(ceiling_reg_of[c], SAMPLE_W'(hi));
    endtask

    // Waits until every queued set is sent and every window has come back.
    task automatic drain_and_settle();
        while (sets_pending.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (level_sets_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [IN_DATA_W-1:0] pack_set(input logic [SAMPLE_W-1:0] a,
                                                      input logic [SAMPLE_W-1:0] b,
                                                      input logic [SAMPLE_W-1:0] c,
                                                      input logic [SAMPLE_W-1:0] d);
        return {d, c, b, a};
    endfunction

    task automatic queue_sets(input int n, input logic [SAMPLE_W-1:0] a,
                              input logic [SAMPLE_W-1:0] b, input logic [SAMPLE_W-1:0] c,
                              input logic [SAMPLE_W-1:0] d);
        repeat (n) sets_pending.push_back(pack_set(a, b, c, d));
    endtask

    // Value within a few counts of base, kept on the 12-bit scale.
    function automatic logic [SAMPLE_W-1:0] jitter_around(input int unsigned base,
                                                          input int spread);
        int v;
        v = int'(base) + int'($urandom_range(2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        return SAMPLE_W'(v);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input t_sample_mix mix, input int c,
                                                        input int unsigned centre);
        case (mix)
            MIX_NEAR_FLOOR:   return jitter_around(floor_cfg[c], 6);
            MIX_NEAR_CEILING: return jitter_around(ceiling_cfg[c], 6);
            MIX_RAILS:        return $urandom_range(1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
            MIX_CLUSTER:      return jitter_around(centre, 3);
            default:          return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Floor and ceiling for one channel under a given setup.
    task automatic pick_bounds(input int setup, input int c,
                               output int unsigned lo, output int unsigned hi);
        case (setup % RAND_PHASES)
            0: begin lo = 0; hi = SAMPLE_MAX; end
            1: begin lo = $urandom_range(1500); hi = $urandom_range(SAMPLE_MAX, 2500); end
            2: begin lo = $urandom_range(SAMPLE_MAX); hi = lo; end
            3: begin lo = $urandom_range(SAMPLE_MAX, 2048); hi = $urandom_range(2047); end
            4: begin lo = c[0] ? SAMPLE_MAX : 0; hi = lo; end
            5: begin lo = $urandom_range(4000); hi = lo + $urandom_range(16, 1); end
            6: begin lo = $urandom & SAMPLE_MAX; hi = $urandom & SAMPLE_MAX; end
            default: begin lo = $urandom_range(10); hi = $urandom_range(SAMPLE_MAX, 4085); end
        endcase
    endtask

    initial begin
        t_sample_mix          mix[CHANNELS];
        int unsigned          centre[CHANNELS];
        logic [SAMPLE_W-1:0]  s[CHANNELS];
        int unsigned          lo;
        int unsigned          hi;
        int                   queued;

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setup: zero input, full-scale saturation, an exact ceiling hit,
        // and a window whose peak and trough sit on both rails.
        queue_sets(5, 0, 0, 0, 0);
        queue_sets(5, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        queue_sets(1, 3800, 1, SAMPLE_MAX, 100);
        queue_sets(1, 0, 2, 0, 100);
        queue_sets(1, SAMPLE_MAX, 3, SAMPLE_MAX, 100);
        queue_sets(1, 3800, 4, 0, 100);
        queue_sets(1, 3800, 5, 2048, 100);
        drain_and_settle();

        // Equal bounds, inverted bounds, full span and a floor on the top rail.
        program_channel(0, 2000, 2000);
        program_channel(1, 3000, 1000);
        program_channel(2, 0, SAMPLE_MAX);
        program_channel(3, SAMPLE_MAX, 0);
        setups++;
        queue_sets(5, 2001, 3000, SAMPLE_MAX, SAMPLE_MAX);
        queue_sets(5, 2000, 3001, 1, 0);
        drain_and_settle();
        queued = 25;

        // Random phases; each one pauses the sender until every window is back.
        for (int p = 0; p < RAND_PHASES; p++) begin
            for (int c = 0; c < CHANNELS; c++) begin
                pick_bounds(p, c, lo, hi);
                program_channel(c, lo, hi);
            end
            setups++;
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // A fresh draw style per channel at the start of every window.
                if (queued % WINDOW_SAMPLES == 0) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        mix[c]    = t_sample_mix'($urandom_range(MIX_CLUSTER));
                        centre[c] = $urandom & SAMPLE_MAX;
                    end
                end
                for (int c = 0; c < CHANNELS; c++) begin
                    s[c] = pick_sample(mix[c], c, centre[c]);
                end
                sets_pending.push_back(pack_set(s[0], s[1], s[2], s[3]));
                queued++;
            end
            drain_and_settle();
        end

        $display("Covered %0d sample sets and %0d checked windows across %0d setups",
                 sets_taken, level_sets_checked, setups + 1);
        $display("(%0d register writes, %0d mismatches)", reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Timed out with %0d windows outstanding", level_sets_due.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tmn_pkg.sv
hdl/tmn_front.sv
hdl/tmn_queue.sv
hdl/tmn_back.sv
hdl/trimmed_mean_normalizer.sv
sim/tb.sv
